/* rtl/packed_bitmap_centered_blitter_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packed bitmap blitter
// Shorthand for clocked concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PACKED_BITMAP_CENTERED_BLITTER_UNIT_MACROS_SVH
`define PACKED_BITMAP_CENTERED_BLITTER_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define PBCB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is also checked across reset.
`define PBCB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/pbcb_pkg.sv */
// ----------------------------------------------------------------------------
// Packed bitmap blitter package
// Result kinds, the header magic and the work item passed from parser to emitter.
// ----------------------------------------------------------------------------
package pbcb_pkg;

   localparam logic [2:0] K_PIXEL  = 3'd0;
   localparam logic [2:0] K_OK     = 3'd1;
   localparam logic [2:0] K_BADHDR = 3'd2;
   localparam logic [2:0] K_WIDE   = 3'd3;
   localparam logic [2:0] K_TRUNC  = 3'd4;

   localparam logic [7:0] MAGIC_WORD [4] = '{8'h4D, 8'h4F, 8'h4F, 8'h4E};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One parsed byte: the pixels still to be drawn and an optional closing status.
   typedef struct packed {
      logic [7:0]  bits;
      logic [12:0] x_base;
      logic [15:0] y;
      logic        has_status;
      logic [2:0]  kind;
   } item_type;

endpackage

/* rtl/pbcb_front.sv */
// ----------------------------------------------------------------------------
// Packed bitmap blitter parser
// Walks the file header and rows, one byte per accepted cycle, and builds work items.
// ----------------------------------------------------------------------------
module pbcb_front import pbcb_pkg::*; #(
   parameter int MAX_ROW_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] display_width,
   input  logic [11:0] display_height,
   input  logic        byte_accept,
   input  logic [7:0]  data_byte,
   input  logic        first_byte,
   input  logic        last_byte,
   output logic        push,
   output item_type    item
);

   localparam int BIR_W = $clog2(MAX_ROW_BYTES + 1);
   localparam logic [13:0] MAX_RB = 14'(MAX_ROW_BYTES);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_ROWS = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       hcount_ff, hcount_in;
   logic             magic_ff, magic_in;
   logic [15:0]      width_ff, width_in;
   logic [15:0]      height_ff, height_in;
   logic [BIR_W-1:0] bir_ff, bir_in;
   logic [BIR_W-1:0] rbytes_ff, rbytes_in;
   logic [15:0]      row_ff, row_in;
   logic [12:0]      left_ff, left_in;
   logic [15:0]      top_ff, top_in;

   logic [1:0]        phase_eff;
   logic [2:0]        hcount_eff;
   logic              magic_eff;
   logic [15:0]       full_h;
   logic [13:0]       rb_full;
   logic signed [17:0] dw_diff, dh_diff, dw_half, dh_half;
   logic [7:0]        mask;
   logic              row_end;
   logic [16:0]       row_next;

   always_comb begin
      phase_eff  = first_byte ? PH_HEAD : phase_ff;
      hcount_eff = first_byte ? 3'd0 : hcount_ff;
      magic_eff  = first_byte ? 1'b1 : magic_ff;
      full_h     = {data_byte, height_ff[7:0]};
      rb_full    = 14'(({1'b0, width_ff} + 17'd7) >> 3);
      dw_diff    = $signed({6'b0, display_width}) - $signed({2'b0, width_ff});
      dh_diff    = $signed({6'b0, display_height}) - $signed({2'b0, full_h});
      // Halve with truncation toward zero: add one before the shift when negative.
      dw_half    = (dw_diff + $signed({17'b0, dw_diff[17]})) >>> 1;
      dh_half    = (dh_diff + $signed({17'b0, dh_diff[17]})) >>> 1;
      row_end    = ({1'b0, bir_ff} + 1'b1) >= {1'b0, rbytes_ff};
      row_next   = {1'b0, row_ff} + 17'd1;
      // The last byte of a row carries only width mod 8 pixels (all eight when zero).
      mask       = row_end ? (8'hFF << (3'd0 - width_ff[2:0])) : 8'hFF;
   end

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      magic_in  = magic_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bir_in    = bir_ff;
      rbytes_in = rbytes_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      push      = 1'b0;
      item      = '0;
      if (byte_accept) begin
         unique case (phase_eff)
            PH_HEAD: begin
               phase_in  = PH_HEAD;
               hcount_in = hcount_eff + 3'd1;
               magic_in  = magic_eff;
               if (hcount_eff[2] == 1'b0) begin
                  if (data_byte != MAGIC_WORD[hcount_eff[1:0]]) begin
                     magic_in = 1'b0;
                  end
               end
               case (hcount_eff)
                  3'd4:    width_in  = {width_ff[15:8], data_byte};
                  3'd5:    width_in  = {data_byte, width_ff[7:0]};
                  3'd6:    height_in = {height_ff[15:8], data_byte};
                  3'd7:    height_in = full_h;
                  default: ;
               endcase
               if (hcount_eff == 3'd7) begin
                  rbytes_in = BIR_W'(rb_full);
                  left_in   = dw_half[12:0];
                  top_in    = dh_half[15:0];
                  bir_in    = '0;
                  row_in    = '0;
                  push      = 1'b1;
                  item.has_status = 1'b1;
                  phase_in  = PH_IDLE;
                  if (!magic_eff) begin
                     item.kind = K_BADHDR;
                  end else if (rb_full > MAX_RB) begin
                     item.kind = K_WIDE;
                  end else if (full_h == 16'd0 || rb_full == 14'd0) begin
                     item.kind = K_OK;
                  end else if (last_byte) begin
                     item.kind = K_TRUNC;
                  end else begin
                     push            = 1'b0;
                     item.has_status = 1'b0;
                     phase_in        = PH_ROWS;
                  end
               end else if (last_byte) begin
                  push            = 1'b1;
                  item.has_status = 1'b1;
                  item.kind       = K_BADHDR;
                  phase_in        = PH_IDLE;
               end
            end
            PH_ROWS: begin
               item.bits   = data_byte & mask;
               item.x_base = left_ff + 13'({bir_ff, 3'b000});
               item.y      = top_ff + row_ff;
               bir_in      = row_end ? '0 : bir_ff + 1'b1;
               if (row_end) begin
                  row_in = row_next[15:0];
               end
               if (row_end && row_next >= {1'b0, height_ff}) begin
                  item.has_status = 1'b1;
                  item.kind       = K_OK;
                  phase_in        = PH_IDLE;
               end else if (last_byte) begin
                  item.has_status = 1'b1;
                  item.kind       = K_TRUNC;
                  phase_in        = PH_IDLE;
               end
               push = (item.bits != 8'd0) || item.has_status;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hcount_ff <= '0;
         magic_ff  <= 1'b1;
         width_ff  <= '0;
         height_ff <= '0;
         bir_ff    <= '0;
         rbytes_ff <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         top_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         magic_ff  <= magic_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bir_ff    <= bir_in;
         rbytes_ff <= rbytes_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
      end
   end

endmodule

/* rtl/pbcb_queue.sv */
// ----------------------------------------------------------------------------
// Packed bitmap blitter work queue
// Short first-in first-out store between the parser and the pixel emitter.
// ----------------------------------------------------------------------------
module pbcb_queue import pbcb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   item_type          store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/pbcb_back.sv */
// ----------------------------------------------------------------------------
// Packed bitmap blitter pixel emitter
// Expands each work item into pixel writes, most significant bit first, then status.
// ----------------------------------------------------------------------------
module pbcb_back import pbcb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  item_type    q_head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   item_type    work_ff, work_in;
   logic        work_valid_ff, work_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic [12:0] out_x_ff, out_x_in;
   logic [15:0] out_y_ff, out_y_in;
   logic [2:0]  out_kind_ff, out_kind_in;
   logic        out_last_ff, out_last_in;

   logic       slot_free;
   logic [2:0] idx;
   logic [7:0] bits_left;
   logic       finish;

   assign slot_free = !out_valid_ff || rsp_tready;

   // Leftmost remaining pixel: index counted from the most significant bit.
   always_comb begin
      idx = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (work_ff.bits[i]) begin
            idx = 3'(7 - i);
         end
      end
      bits_left = work_ff.bits & ~(8'h80 >> idx);
   end

   always_comb begin
      work_in      = work_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      finish       = 1'b0;
      if (work_valid_ff && slot_free) begin
         out_valid_in = 1'b1;
         if (work_ff.bits != 8'd0) begin
            out_x_in     = work_ff.x_base + 13'(idx);
            out_y_in     = work_ff.y;
            out_kind_in  = K_PIXEL;
            out_last_in  = (bits_left == 8'd0) && !work_ff.has_status;
            work_in.bits = bits_left;
            finish       = out_last_in;
         end else begin
            out_x_in    = '0;
            out_y_in    = '0;
            out_kind_in = work_ff.kind;
            out_last_in = 1'b1;
            finish      = 1'b1;
         end
      end
      q_pop         = q_not_empty && (!work_valid_ff || finish);
      work_valid_in = q_pop || (work_valid_ff && !finish);
      if (q_pop) begin
         work_in = q_head;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

/* rtl/packed_bitmap_centered_blitter_unit.sv */
// ----------------------------------------------------------------------------
// Packed bitmap centred blitter
// Parses a 1-bit image file byte by byte and emits centred pixel writes.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on the req_ channel as long as its
// internal work queue (four entries) has room, and delivers at most one result
// per cycle on the rsp_ channel. A byte yields one result per lit pixel in it
// plus one when it closes the file, so zero to nine results; the output port,
// one result per cycle while rsp_tready is high, sets the sustained rate. A
// result is held in an output register, so bytes keep being parsed while a
// result waits to be taken. Each file opens with the four bytes MOON and then
// little-endian width and height; each file ends in exactly one status (done,
// bad header, row too wide, truncated), after which bytes are dropped until one
// arrives marked as the first of a file. The user sets display size through
// the csr_ port only while no transaction is in flight; it is not enforced.
module packed_bitmap_centered_blitter_unit import pbcb_pkg::*; #(
   parameter int MAX_ROW_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Byte input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   // Result output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_x [12:0], pixel_y [28:13], zero [31:29]
   output logic [2:0]  rsp_tuser,   // result_kind [2:0]
   output logic        rsp_tlast,   // last_of_run
   // Register writes: index 0 display width, index 1 display height.
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [11:0] csr_wdata
);

   logic [11:0] disp_w_ff, disp_w_in;
   logic [11:0] disp_h_ff, disp_h_in;

   logic     byte_accept;
   logic     push;
   item_type push_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   item_type q_head;

   // Register writes land directly; there is no read-back.
   always_comb begin
      disp_w_in = disp_w_ff;
      disp_h_in = disp_h_ff;
      if (csr_we) begin
         if (csr_addr) begin
            disp_h_in = csr_wdata;
         end else begin
            disp_w_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_w_ff <= 12'd800;
         disp_h_ff <= 12'd480;
      end else begin
         disp_w_ff <= disp_w_in;
         disp_h_ff <= disp_h_in;
      end
   end

   // A byte is taken whenever the queue can hold whatever item it makes.
   assign req_tready  = !q_full;
   assign byte_accept = req_tvalid && req_tready;

   pbcb_front #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .display_width (disp_w_ff),
      .display_height(disp_h_ff),
      .byte_accept   (byte_accept),
      .data_byte     (req_tdata),
      .first_byte    (req_tuser),
      .last_byte     (req_tlast),
      .push          (push),
      .item          (push_item)
   );

   pbcb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (q_pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head     (q_head)
   );

   pbcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/pbcb_checker.sv */
// ----------------------------------------------------------------------------
// Packed bitmap blitter port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "packed_bitmap_centered_blitter_unit_macros.svh"

module pbcb_checker import pbcb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `PBCB_ASSERT_RST(a_idle_after_reset, reset |=> !rsp_tvalid, "result valid after reset")

   `PBCB_ASSERT(a_hold_when_stalled, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   `PBCB_ASSERT(a_kind_range, rsp_tvalid |-> (rsp_tuser == K_PIXEL || rsp_tuser == K_OK || rsp_tuser == K_BADHDR || rsp_tuser == K_WIDE || rsp_tuser == K_TRUNC), "unknown result kind")

   `PBCB_ASSERT(a_status_shape, rsp_tvalid && rsp_tuser != K_PIXEL |-> rsp_tlast && rsp_tdata == 32'd0, "status result not last or carries coordinates")

endmodule

bind packed_bitmap_centered_blitter_unit pbcb_checker u_pbcb_checker (.*);
